### design/json_string_unescaper_unit_macros.svh
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPER_UNIT_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jsu assertion failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jsu assertion failed");

`endif

### design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Modes, result codes, result word type and the decode helper functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_HEX,
      MODE_HELD,
      MODE_HELD_BS,
      MODE_HEX_LO
   } mode_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd1;
   localparam logic [1:0] ERR_BAD_UNICODE  = 2'd2;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

   localparam int MaxResults = 6;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;

   localparam logic [15:0] SURR_HI_MIN = 16'hD800;
   localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
   localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
   localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
   localparam logic [20:0] PLANE1_BASE = 21'h10000;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [1:0] err;
   } entry_type;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;   // bytes[0] goes out first
   } utf8_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < PLANE1_BASE) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      case (c) inside
         [8'h30:8'h39]:               r = {1'b1, c[3:0]};
         [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
         default:                     r = 5'd0;
      endcase
      return r;
   endfunction

   // {valid, mapped byte} for the simple escapes
   function automatic logic [8:0] escape_map(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

### design/json_string_unescaper_unit.sv
// ----------------------------------------------------------------------------
// JSON string unescaper unit
// Decodes a JSON string body byte stream into UTF-8 bytes, end and error words.
// ----------------------------------------------------------------------------
// channel  dir  tdata          tuser                 tlast
// req      in   in_byte[7:0]   -                     input_ends
// rsp      out  out_byte[7:0]  kind[1:0] err[3:2]    last_of_run
//
// With rsp ready: one input word per cycle if each gives at most one result word.
// A word that decodes to N result words holds req while the rsp port drains them;
// N is 0 to 6, set by MaxResults, the depth of the output list that drains them.
// An accepted req word reaches rsp through the pending and output list stages.
// Reset clears decode state and both list stages; rsp stalls back up to req.
// ----------------------------------------------------------------------------
module json_string_unescaper_unit
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // input_ends
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [3:0] rsp_tuser,   // kind[1:0], error_code[3:2]
   output logic       rsp_tlast    // last_of_run
);

   // decode state
   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] held_ff, held_in;

   // pending list stage
   logic                       p_valid_ff, p_valid_in;
   entry_type [MaxResults-1:0] p_list_ff;
   logic [2:0]                 p_num_ff;

   // output list stage
   logic                       o_valid_ff;
   entry_type [MaxResults-1:0] o_list_ff;
   logic [2:0]                 o_num_ff;
   logic [2:0]                 o_idx_ff;

   logic accept, move, o_last, o_done;

   // decode
   logic [4:0]                 hexd;
   logic [8:0]                 escd;
   logic [15:0]                acc_next;
   logic                       is_hi, is_lo;
   utf8_type                   held_enc, code_enc, pair_enc, body;
   logic                       held_out, closed;
   logic [1:0]                 err;
   entry_type [MaxResults-1:0] gen_list;
   logic [2:0]                 gen_num;
   logic [3:0]                 base, pos;

   assign hexd     = hex_decode(req_tdata);
   assign escd     = escape_map(req_tdata);
   assign acc_next = {acc_ff[11:0], hexd[3:0]};
   assign is_hi    = (acc_next >= SURR_HI_MIN) && (acc_next <= SURR_HI_MAX);
   assign is_lo    = (acc_next >= SURR_LO_MIN) && (acc_next <= SURR_LO_MAX);
   assign held_enc = utf8_encode({5'd0, held_ff});
   assign code_enc = utf8_encode({5'd0, acc_next});
   assign pair_enc = utf8_encode(PLANE1_BASE + {1'b0, held_ff[9:0], acc_next[9:0]});

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      held_in  = held_ff;
      err      = ERR_NONE;
      closed   = 1'b0;
      held_out = 1'b0;
      body     = '0;
      case (mode_ff)
         MODE_NORMAL: begin
            if (req_tdata == CHAR_QUOTE) begin
               closed = 1'b1;
            end else if (req_tdata == CHAR_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               body.len      = 3'd1;
               body.bytes[0] = req_tdata;
            end
         end
         MODE_ESC: begin
            if (escd[8]) begin
               body.len      = 3'd1;
               body.bytes[0] = escd[7:0];
               mode_in       = MODE_NORMAL;
            end else if (req_tdata == CHAR_U) begin
               mode_in = MODE_HEX;
               acc_in  = '0;
               cnt_in  = '0;
            end else begin
               err = ERR_BAD_ESCAPE;
            end
         end
         MODE_HEX, MODE_HEX_LO: begin
            if (!hexd[4]) begin
               err = ERR_BAD_UNICODE;
            end else if (cnt_ff != 2'd3) begin
               acc_in = acc_next;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               if (mode_ff == MODE_HEX_LO && is_lo) begin
                  body    = pair_enc;
                  held_in = '0;
                  mode_in = MODE_NORMAL;
               end else begin
                  if (mode_ff == MODE_HEX_LO) begin
                     held_out = 1'b1;
                     held_in  = '0;
                  end
                  if (is_hi) begin
                     held_in = acc_next;
                     mode_in = MODE_HELD;
                  end else begin
                     body    = code_enc;
                     mode_in = MODE_NORMAL;
                  end
               end
            end
         end
         MODE_HELD: begin
            if (req_tdata == CHAR_BSLASH) begin
               mode_in = MODE_HELD_BS;
            end else begin
               held_out = 1'b1;
               held_in  = '0;
               mode_in  = MODE_NORMAL;
               if (req_tdata == CHAR_QUOTE) begin
                  closed = 1'b1;
               end else begin
                  body.len      = 3'd1;
                  body.bytes[0] = req_tdata;
               end
            end
         end
         MODE_HELD_BS: begin
            if (req_tdata == CHAR_U) begin
               mode_in = MODE_HEX_LO;
               acc_in  = '0;
               cnt_in  = '0;
            end else begin
               held_out = 1'b1;
               held_in  = '0;
               if (escd[8]) begin
                  body.len      = 3'd1;
                  body.bytes[0] = escd[7:0];
                  mode_in       = MODE_NORMAL;
               end else begin
                  err = ERR_BAD_ESCAPE;
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase

      if (err == ERR_NONE && !closed && req_tlast) begin
         err = (mode_in == MODE_HEX || mode_in == MODE_HEX_LO) ?
               ERR_BAD_UNICODE : ERR_UNTERMINATED;
      end

      gen_list = '0;
      base     = held_out ? 4'd3 : 4'd0;
      pos      = base + {1'b0, body.len};
      if (err != ERR_NONE) begin
         gen_list[0] = '{data: 8'h00, kind: KIND_ERROR, err: err};
         pos         = 4'd1;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (held_out) begin
               gen_list[i] = '{data: held_enc.bytes[i], kind: KIND_DATA, err: ERR_NONE};
            end
         end
         for (int j = 0; j < 4; j++) begin
            if (3'(j) < body.len && (base + 4'(j)) < 4'(MaxResults)) begin
               gen_list[3'(base + 4'(j))] =
                  '{data: body.bytes[j], kind: KIND_DATA, err: ERR_NONE};
            end
         end
         if (closed && pos < 4'(MaxResults)) begin
            gen_list[pos[2:0]] = '{data: 8'h00, kind: KIND_END, err: ERR_NONE};
            pos = pos + 4'd1;
         end
      end
      gen_num = pos[2:0];

      if (err != ERR_NONE || closed) begin
         mode_in = MODE_NORMAL;
         acc_in  = '0;
         cnt_in  = '0;
         held_in = '0;
      end
   end

   // handshake
   assign o_last     = (o_idx_ff == o_num_ff - 3'd1);
   assign o_done     = o_valid_ff && rsp_tready && o_last;
   assign move       = p_valid_ff && (!o_valid_ff || o_done);
   assign req_tready = !p_valid_ff || move;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      p_valid_in = p_valid_ff;
      if (move) begin
         p_valid_in = 1'b0;
      end
      if (accept && gen_num != 3'd0) begin
         p_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         held_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
      if (accept && gen_num != 3'd0) begin
         p_list_ff <= gen_list;
         p_num_ff  <= gen_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         o_idx_ff   <= '0;
      end else if (move) begin
         o_valid_ff <= 1'b1;
         o_idx_ff   <= '0;
      end else if (o_valid_ff && rsp_tready) begin
         if (o_last) begin
            o_valid_ff <= 1'b0;
         end else begin
            o_idx_ff <= o_idx_ff + 3'd1;
         end
      end
      if (move) begin
         o_list_ff <= p_list_ff;
         o_num_ff  <= p_num_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_list_ff[o_idx_ff].data;
   assign rsp_tuser  = {o_list_ff[o_idx_ff].err, o_list_ff[o_idx_ff].kind};
   assign rsp_tlast  = o_last;

endmodule

### design/jsu_checker.sv
// ----------------------------------------------------------------------------
// JSON string unescaper checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_unit_macros.svh"

module jsu_checker
   import jsu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [3:0] rsp_tuser,
   input logic       rsp_tlast
);

   logic rsp_stall;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `JSU_ASSERT_NEXT(a_rsp_valid_holds, rsp_stall, rsp_tvalid)
   `JSU_ASSERT_NEXT(a_rsp_word_holds, rsp_stall,
                    $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `JSU_ASSERT_NOW(a_error_is_last, rsp_tvalid && rsp_tuser[1:0] == KIND_ERROR,
                   rsp_tlast && rsp_tuser[3:2] != ERR_NONE)
   `JSU_ASSERT_NOW(a_end_is_last, rsp_tvalid && rsp_tuser[1:0] == KIND_END,
                   rsp_tlast && rsp_tuser[3:2] == ERR_NONE && rsp_tdata == 8'h00)
   `JSU_ASSERT_NOW(a_data_no_error, rsp_tvalid && rsp_tuser[1:0] == KIND_DATA,
                   rsp_tuser[3:2] == ERR_NONE)

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (.*);
